FILE: hdl/alt_pkg.sv
`default_nettype none

package alt_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_TOKENS_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Results one input character can cause: close, character, close, line end
    localparam int NUM_SLOTS = 4;

    localparam logic [7:0] SEP_RESET = 8'd32;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_S  = 8'h73;
    localparam logic [7:0] CH_LOW_L  = 8'h6c;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_LINE = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        TK_OPCODE   = 4'd0,
        TK_REGISTER = 4'd1,
        TK_HASH     = 4'd2,
        TK_EQ       = 4'd3,
        TK_SHIFT    = 4'd4,
        TK_PLUS     = 4'd5,
        TK_MINUS    = 4'd6,
        TK_COMMA    = 4'd7,
        TK_LBRACKET = 4'd8,
        TK_RBRACKET = 4'd9,
        TK_LABEL    = 4'd10,
        TK_STRING   = 4'd11
    } t_tok;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [5:0]  idx;
        t_tok        tk;
        logic [6:0]  cnt;
    } t_result;

    // One queue entry: the results caused by one accepted character
    typedef struct packed {
        logic    [NUM_SLOTS-1:0] vld;
        t_result [NUM_SLOTS-1:0] res;
    } t_record;

    // Letter at position pos of shift word w (asr, lsl, lsr)
    function automatic logic [7:0] shift_char(logic [1:0] w, logic [1:0] pos);
        logic [7:0] r;
        case ({w, pos})
            4'b00_00: r = CH_LOW_A;
            4'b00_01: r = CH_LOW_S;
            4'b00_10: r = CH_LOW_R;
            4'b01_00: r = CH_LOW_L;
            4'b01_01: r = CH_LOW_S;
            4'b01_10: r = CH_LOW_L;
            4'b10_00: r = CH_LOW_L;
            4'b10_01: r = CH_LOW_S;
            4'b10_10: r = CH_LOW_R;
            default:  r = 8'h00;
        endcase
        return r;
    endfunction

    // Narrow the shift-word match with the next character of the token
    function automatic logic [2:0] take_match(logic [2:0] m, logic [2:0] len,
                                              logic [7:0] c);
        logic [2:0] r;
        r = m;
        if (len < 3'd3) begin
            for (int w = 0; w < 3; w++) begin
                if (shift_char(2'(w), len[1:0]) != c) r[w] = 1'b0;
            end
        end else begin
            r = '0;
        end
        return r;
    endfunction

    function automatic t_tok type_of(logic [7:0] c, logic [2:0] len, logic [2:0] m);
        t_tok r;
        case (c)
            CH_PLUS:   r = TK_PLUS;
            CH_MINUS:  r = TK_MINUS;
            CH_COMMA:  r = TK_COMMA;
            CH_LBRACK: r = TK_LBRACKET;
            CH_RBRACK: r = TK_RBRACKET;
            CH_EQ:     r = TK_EQ;
            CH_HASH:   r = TK_HASH;
            CH_COLON:  r = TK_LABEL;
            CH_LOW_R:  r = TK_REGISTER;
            default:   r = (len == 3'd3 && m != 3'd0) ? TK_SHIFT : TK_STRING;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] cur_index(logic [6:0] seen, logic [5:0] cap);
        return (seen < {1'b0, cap}) ? seen[5:0] : cap;
    endfunction

    // Token-end result for the open token
    function automatic t_result close_res(logic [6:0] seen, logic [7:0] first,
                                          logic [2:0] len, logic [2:0] m,
                                          logic [5:0] cap);
        t_result r;
        r.kind = KIND_END;
        r.ch   = 8'h00;
        r.idx  = cur_index(seen, cap);
        r.tk   = (seen == 7'd0) ? TK_OPCODE : type_of(first, len, m);
        r.cnt  = 7'd0;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/alt_fifo.sv
`default_nettype none

module alt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = alt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output      logic             o_full,
    input  wire logic             i_pop,
    output      logic [WIDTH-1:0] o_data,
    output      logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/alt_front.sv
`default_nettype none

module alt_front #(
    parameter int MAX_TOKENS = alt_pkg::MAX_TOKENS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    input  wire logic [7:0]      i_cfg_data,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_char_in,
    input  wire logic            i_line_last,
    output      logic            o_rec_push,
    output      alt_pkg::t_record o_rec
);

    localparam int COUNT_CAP = (MAX_TOKENS < 127) ? MAX_TOKENS : 127;
    localparam int INDEX_CAP = ((MAX_TOKENS - 1) < 63) ? (MAX_TOKENS - 1) : 63;
    localparam logic [6:0] COUNT_CAP_V = 7'(COUNT_CAP);
    localparam logic [5:0] INDEX_CAP_V = 6'(INDEX_CAP);

    logic [7:0] r_sep;
    logic       r_open,  n_open;
    logic [7:0] r_first, n_first;
    logic [2:0] r_len,   n_len;
    logic [2:0] r_match, n_match;
    logic [6:0] r_seen,  n_seen;
    logic       r_ended, n_ended;
    alt_pkg::t_record rec;

    function automatic logic [6:0] sat_inc(logic [6:0] s);
        return (s < COUNT_CAP_V) ? s + 7'd1 : s;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic       is_end, is_delim;
        c        = i_char_in;
        is_end   = (c == alt_pkg::CH_CR) || (c == alt_pkg::CH_LF) || (c == alt_pkg::CH_NUL);
        is_delim = (c == alt_pkg::CH_LBRACK) || (c == alt_pkg::CH_RBRACK)
                || (c == alt_pkg::CH_COMMA) || (c == alt_pkg::CH_COLON);
        n_open  = r_open;
        n_first = r_first;
        n_len   = r_len;
        n_match = r_match;
        n_seen  = r_seen;
        n_ended = r_ended;
        rec     = '0;

        if (!r_ended) begin
            // Close the open token on end, separator or delimiter
            if ((is_end || c == r_sep || is_delim) && n_open) begin
                rec.vld[0] = 1'b1;
                rec.res[0] = alt_pkg::close_res(n_seen, n_first, n_len, n_match,
                                                INDEX_CAP_V);
                n_seen  = sat_inc(n_seen);
                n_open  = 1'b0;
                n_first = 8'h00;
                n_len   = 3'd0;
                n_match = 3'b111;
            end
            if (is_end) begin
                n_ended = 1'b1;
            end else if (c != r_sep) begin
                // Take the character into the token and report it
                n_match = alt_pkg::take_match(n_match, n_len, c);
                if (!n_open) begin
                    n_open  = 1'b1;
                    n_first = c;
                end
                if (n_len < 3'd7) n_len = n_len + 3'd1;
                rec.vld[1]     = 1'b1;
                rec.res[1]     = '0;
                rec.res[1].kind = alt_pkg::KIND_CHAR;
                rec.res[1].ch   = c;
                rec.res[1].idx  = alt_pkg::cur_index(n_seen, INDEX_CAP_V);
                if (is_delim) begin
                    // A delimiter is a token of its own
                    rec.vld[2] = 1'b1;
                    rec.res[2] = alt_pkg::close_res(n_seen, n_first, n_len, n_match,
                                                    INDEX_CAP_V);
                    n_seen  = sat_inc(n_seen);
                    n_open  = 1'b0;
                    n_first = 8'h00;
                    n_len   = 3'd0;
                    n_match = 3'b111;
                end
            end
        end

        if (i_line_last) begin
            if (n_open) begin
                rec.vld[2] = 1'b1;
                rec.res[2] = alt_pkg::close_res(n_seen, n_first, n_len, n_match,
                                                INDEX_CAP_V);
                n_seen = sat_inc(n_seen);
            end
            rec.vld[3]      = 1'b1;
            rec.res[3]      = '0;
            rec.res[3].kind = alt_pkg::KIND_LINE;
            rec.res[3].cnt  = n_seen;
            n_open  = 1'b0;
            n_first = 8'h00;
            n_len   = 3'd0;
            n_match = 3'b111;
            n_seen  = 7'd0;
            n_ended = 1'b0;
        end
    end

    assign o_rec      = rec;
    assign o_rec_push = i_accept && (rec.vld != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep   <= alt_pkg::SEP_RESET;
            r_open  <= 1'b0;
            r_first <= 8'h00;
            r_len   <= 3'd0;
            r_match <= 3'b111;
            r_seen  <= 7'd0;
            r_ended <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sep <= i_cfg_data;
            end
            if (i_accept) begin
                r_open  <= n_open;
                r_first <= n_first;
                r_len   <= n_len;
                r_match <= n_match;
                r_seen  <= n_seen;
                r_ended <= n_ended;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/alt_back.sv
`default_nettype none

module alt_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire alt_pkg::t_record i_rec,
    input  wire logic             i_rec_empty,
    output      logic             o_rec_pop,
    input  wire logic             i_pop,
    output      logic             o_empty,
    output      alt_pkg::t_result o_res,
    output      logic             o_run_last
);

    localparam int NS = alt_pkg::NUM_SLOTS;

    logic [NS-1:0]    r_used, n_used;
    logic             r_vld;
    alt_pkg::t_result r_res;
    logic             r_last;
    logic [NS-1:0]    remain, after;
    logic [1:0]       sel;
    logic             take;

    always_comb begin
        logic found;
        found  = 1'b0;
        sel    = 2'd0;
        remain = i_rec.vld & ~r_used;
        for (int i = 0; i < NS; i++) begin
            if (remain[i] && !found) begin
                found = 1'b1;
                sel   = 2'(i);
            end
        end
        after = remain & ~(NS'(1) << sel);
        take  = !i_rec_empty && (!r_vld || i_pop);
        // Drop the entry once its last result leaves
        o_rec_pop = take && (after == '0);
        n_used = r_used;
        if (take) begin
            n_used = (after == '0) ? '0 : (r_used | (NS'(1) << sel));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_used <= n_used;
            if (take) begin
                r_vld <= 1'b1;
            end else if (i_pop) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res  <= i_rec.res[sel];
            r_last <= (after == '0);
        end
    end

    assign o_empty    = !r_vld;
    assign o_res      = r_res;
    assign o_run_last = r_last;

endmodule

`default_nettype wire

FILE: hdl/assembly_line_tokenizer_top.sv
// A result passes through the record queue and the back's output register to the result ports.
// Throughput: one character per cycle unless full; the result side drains one result per cycle,
//   and a character causes up to four results, so long delimiter runs fill the queue.
// The input stalls (full) only when the record queue between front and back is full.
// Reset: synchronous, active low; clears line state and queues, separator back to space.
`default_nettype none

module assembly_line_tokenizer_top #(
    parameter int MAX_TOKENS  = alt_pkg::MAX_TOKENS_DEF,
    parameter int QUEUE_DEPTH = alt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration: separator character
    input  wire logic       i_cfg_valid,
    output      logic       o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    // Character input, queue style
    input  wire logic       push,
    output      logic       full,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_line_last,
    // Result output, queue style
    output      logic       empty,
    input  wire logic       pop,
    output      logic [1:0] o_kind,
    output      logic [7:0] o_char_out,
    output      logic [5:0] o_token_index,
    output      logic [3:0] o_token_kind,
    output      logic [6:0] o_token_count,
    output      logic       o_run_last
);

    logic             accept;
    logic             rec_push;
    alt_pkg::t_record rec_in;
    alt_pkg::t_record rec_out;
    logic             rec_full;
    logic             rec_empty;
    logic             rec_pop;
    alt_pkg::t_result res;

    // The user must write the register only while idle; no logic here enforces it.
    assign o_cfg_ready = 1'b1;

    // Accept a transaction whenever the record queue has room. The front folds
    // every character into the line state in the same cycle, so the next one
    // can follow directly.
    assign full   = rec_full;
    assign accept = push && !rec_full;

    // Front: classify the character, track the open token and build one
    // record with up to four results (close, character, close, line end).
    alt_front #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_char_in   (i_char_in),
        .i_line_last (i_line_last),
        .o_rec_push  (rec_push),
        .o_rec       (rec_in)
    );

    // Short queue of records: lets the front keep taking characters while the
    // back is still unrolling an earlier multi-result record.
    alt_fifo #(
        .WIDTH ($bits(alt_pkg::t_record)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_data  (rec_in),
        .o_full  (rec_full),
        .i_pop   (rec_pop),
        .o_data  (rec_out),
        .o_empty (rec_empty)
    );

    // Back: emit the valid results of the head record in order, one per cycle while
    // pop is held, through an output register; flag the last one of each record.
    alt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec_out),
        .i_rec_empty (rec_empty),
        .o_rec_pop   (rec_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res),
        .o_run_last  (o_run_last)
    );

    assign o_kind        = res.kind;
    assign o_char_out    = res.ch;
    assign o_token_index = res.idx;
    assign o_token_kind  = res.tk;
    assign o_token_count = res.cnt;

endmodule

`default_nettype wire
